// ----- rtl/core/pnf_pkg.sv -----
package pnf_pkg;

  // word field widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 23;
  localparam int COORD_W = 32;
  localparam int NOISE_W = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int GAIN_W     = 16;
  localparam int OCTCFG_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES = 1'b1;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd32768;
  localparam logic [OCTCFG_W-1:0] OCTCFG_RESET = 4'd4;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOAD_PERM   = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_OFFSET = 2'd1;
  localparam logic [OP_W-1:0] OP_EVAL        = 2'd2;

  // table sizes
  localparam int PERM_SIZE       = 256;
  localparam int PERM_AW         = 8;
  localparam int MAX_OCTAVES_DEF = 8;

endpackage

// ----- rtl/core/pnf_cmd_if.sv -----
interface pnf_cmd_if;
  import pnf_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [IDX_W-1:0]   load_index;
  logic [VAL_W-1:0]   load_value;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;

  modport source (output valid, op, load_index, load_value, coord_x, coord_y, coord_z,
                  input ready);
  modport sink (input valid, op, load_index, load_value, coord_x, coord_y, coord_z,
                output ready);
endinterface

// ----- rtl/core/pnf_res_if.sv -----
interface pnf_res_if;
  import pnf_pkg::*;

  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ----- rtl/core/perlin_noise_fbm_3d_core.sv -----
// Load words (permutation entry, octave offset) leave the sequencer idle, so ready stays high.
// Evaluate words run per octave through offset fetch, fade, hash, lerp and accumulate steps,
// then a normalizing division and hand-off; ready stays low until the sequencer is idle again.
// These steps share a single multiplier and a single permutation read port.
// Synchronous reset idles the sequencer, empties the result register and restores the
// registers to their defaults; permutation and offset tables hold garbage until loaded.
module perlin_noise_fbm_3d_core #(
  parameter int MAX_OCTAVES = pnf_pkg::MAX_OCTAVES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pnf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pnf_pkg::CFG_DATA_W-1:0] cfg_data,
  pnf_cmd_if.sink                        cmd,
  pnf_res_if.source                      res
);
  import pnf_pkg::*;

  localparam int OFF_DEPTH = 3 * MAX_OCTAVES;
  localparam int OFF_AW    = $clog2(OFF_DEPTH);
  localparam int CNT_W     = $clog2(MAX_OCTAVES + 1);
  localparam int OCT_LOG   = $clog2(MAX_OCTAVES);
  localparam int SUM_W     = 17 + OCT_LOG;
  localparam int TOT_W     = 36 + OCT_LOG;
  localparam int REM_W     = TOT_W - 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_OFF  = 3'd1;
  localparam logic [2:0] ST_FADE = 3'd2;
  localparam logic [2:0] ST_HASH = 3'd3;
  localparam logic [2:0] ST_LERP = 3'd4;
  localparam logic [2:0] ST_ACC  = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  // 3d improved gradient, 16 cases
  function automatic logic signed [17:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [17:0] g;
    unique case (h)
      4'h0: g = x + y;
      4'h1: g = y - x;
      4'h2: g = x - y;
      4'h3: g = -x - y;
      4'h4: g = x + z;
      4'h5: g = z - x;
      4'h6: g = x - z;
      4'h7: g = -x - z;
      4'h8: g = y + z;
      4'h9: g = z - y;
      4'hA: g = y - z;
      4'hB: g = -y - z;
      4'hC: g = y + x;
      4'hD: g = z - y;
      4'hE: g = y - x;
      4'hF: g = -y - z;
    endcase
    return g;
  endfunction

  // control
  logic [2:0]       state;
  logic [4:0]       step;
  logic [1:0]       phase;
  logic [1:0]       axis;
  logic [CNT_W-1:0] oct;
  logic [CNT_W-1:0] n_oct;

  // registers
  logic [GAIN_W-1:0]   gain;
  logic [OCTCFG_W-1:0] oct_cfg;

  // datapath registers
  logic [23:0]        crd [3];
  logic [7:0]         lat_idx [3];
  logic [15:0]        frac [3];
  logic [15:0]        fade [3];
  logic [31:0]        t2;
  logic [31:0]        t3;
  logic [19:0]        inner16;
  logic [7:0]         hreg [14];
  logic signed [17:0] la;
  logic signed [18:0] ld;
  logic signed [53:0] prod;
  logic signed [17:0] x1r, x2r, y1r, y2r;
  logic signed [18:0] vr;
  logic [16:0]        amp;
  logic [SUM_W-1:0]   sum;
  logic signed [TOT_W-1:0] total;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   dsh;
  logic [NOISE_W-1:0] quo;
  logic               res_valid;
  logic [NOISE_W-1:0] res_data;

  // memories
  logic [7:0]        perm_mem [PERM_SIZE];
  logic [7:0]        perm_rdata;
  logic [PERM_AW-1:0] perm_raddr;
  logic [VAL_W-1:0]  off_mem [OFF_DEPTH];
  logic [VAL_W-1:0]  off_rdata;
  logic [OFF_AW-1:0] off_raddr;
  logic [7:0]        off_addr8;

  logic cmd_acc;
  logic perm_we;
  logic off_we;

  assign cmd.ready     = (state == ST_IDLE);
  assign cmd_acc       = cmd.valid && cmd.ready;
  assign perm_we       = cmd_acc && (cmd.op == OP_LOAD_PERM);
  assign off_we        = cmd_acc && (cmd.op == OP_LOAD_OFFSET) &&
                         (cmd.load_index < 8'(OFF_DEPTH));
  assign res.valid       = res_valid;
  assign res.noise_value = res_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain    <= GAIN_RESET;
      oct_cfg <= OCTCFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN:    gain    <= cfg_data[GAIN_W-1:0];
        REG_OCTAVES: oct_cfg <= cfg_data[OCTCFG_W-1:0];
      endcase
    end
  end

  // permutation table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[cmd.load_index] <= cmd.load_value[7:0];
    end
    perm_rdata <= perm_mem[perm_raddr];
  end

  // octave offset table
  assign off_addr8 = (8'(oct) << 1) + 8'(oct) + 8'(step[1:0]);
  assign off_raddr = off_addr8[OFF_AW-1:0];

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[cmd.load_index[OFF_AW-1:0]] <= cmd.load_value;
    end
    off_rdata <= off_mem[off_raddr];
  end

  // hash address sequence: a, b, aa, ab, ba, bb, then eight corners
  always_comb begin
    unique case (step)
      5'd0:  perm_raddr = lat_idx[0];
      5'd1:  perm_raddr = lat_idx[0] + 8'd1;
      5'd2:  perm_raddr = hreg[0] + lat_idx[1];
      5'd3:  perm_raddr = hreg[0] + lat_idx[1] + 8'd1;
      5'd4:  perm_raddr = hreg[1] + lat_idx[1];
      5'd5:  perm_raddr = hreg[1] + lat_idx[1] + 8'd1;
      5'd6:  perm_raddr = hreg[2] + lat_idx[2];
      5'd7:  perm_raddr = hreg[4] + lat_idx[2];
      5'd8:  perm_raddr = hreg[3] + lat_idx[2];
      5'd9:  perm_raddr = hreg[5] + lat_idx[2];
      5'd10: perm_raddr = hreg[2] + lat_idx[2] + 8'd1;
      5'd11: perm_raddr = hreg[4] + lat_idx[2] + 8'd1;
      5'd12: perm_raddr = hreg[3] + lat_idx[2] + 8'd1;
      5'd13: perm_raddr = hreg[5] + lat_idx[2] + 8'd1;
      default: perm_raddr = lat_idx[0];
    endcase
  end

  // lattice position for the axis whose offset just arrived
  logic [1:0]  pos_ax;
  logic [23:0] pos_sh;
  logic [23:0] pos;
  assign pos_ax = step[1:0] - 2'd1;
  assign pos_sh = crd[pos_ax] << oct;
  assign pos    = pos_sh + {1'b0, off_rdata};

  // fade polynomial inner term 10 - 15t + 6t^2
  logic [15:0] ft;
  logic [34:0] six_t2;
  logic [19:0] fifteen_t;
  logic [36:0] inner_c;
  assign ft        = frac[axis];
  assign six_t2    = 35'({t2, 2'b00}) + 35'({t2, 1'b0});
  assign fifteen_t = {ft, 4'b0000} - {4'b0000, ft};
  assign inner_c   = (37'd10 << 32) + 37'(six_t2) - 37'({fifteen_t, 16'h0000});

  // lerp operand selection
  logic signed [17:0] xa, xb, yc, zc;
  logic [3:0]         ha, hb;
  logic signed [17:0] la_c, lb_c;
  logic [15:0]        wsel;
  always_comb begin
    xa = {2'b00, frac[0]};
    xb = {2'b11, frac[0]};
    yc = (step == 5'd1 || step == 5'd4) ? {2'b11, frac[1]} : {2'b00, frac[1]};
    zc = (step >= 5'd3) ? {2'b11, frac[2]} : {2'b00, frac[2]};
    unique case (step)
      5'd1:    begin ha = hreg[8][3:0];  hb = hreg[9][3:0];  end
      5'd3:    begin ha = hreg[10][3:0]; hb = hreg[11][3:0]; end
      5'd4:    begin ha = hreg[12][3:0]; hb = hreg[13][3:0]; end
      default: begin ha = hreg[6][3:0];  hb = hreg[7][3:0];  end
    endcase
    unique case (step)
      5'd2, 5'd5: begin la_c = x1r; lb_c = x2r; wsel = fade[1]; end
      5'd6:       begin la_c = y1r; lb_c = y2r; wsel = fade[2]; end
      default: begin
        la_c = grad(ha, xa, yc, zc);
        lb_c = grad(hb, xb, yc, zc);
        wsel = fade[0];
      end
    endcase
  end

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [20:0] mul_b;
  logic signed [53:0] mul_p;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_FADE: begin
        unique case (phase)
          2'd0:    begin mul_a = {17'b0, ft}; mul_b = {5'b0, ft}; end
          2'd1:    begin mul_a = {1'b0, t2};  mul_b = {5'b0, ft}; end
          default: begin mul_a = {1'b0, t3};  mul_b = {1'b0, inner16}; end
        endcase
      end
      ST_LERP: begin
        mul_a = {{14{ld[18]}}, ld};
        mul_b = {5'b0, wsel};
      end
      ST_ACC: begin
        if (phase == 2'd0) begin
          mul_a = {{14{vr[18]}}, vr};
          mul_b = {4'b0, amp};
        end else begin
          mul_a = {16'b0, amp};
          mul_b = {5'b0, gain};
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // lerp result
  logic signed [17:0] mix_r;
  logic signed [18:0] v_c;
  assign mix_r = la + prod[33:16];
  assign v_c   = {la[17], la} + prod[34:16] + 19'sd65536;

  // division setup
  logic [SUM_W:0]   dvs;
  logic [REM_W-1:0] dlim;
  assign dvs  = {sum, 1'b0};
  assign dlim = REM_W'(dvs) << 16;

  logic [4:0] n_clamp;
  always_comb begin
    if (oct_cfg == '0) begin
      n_clamp = 5'd1;
    end else if ({1'b0, oct_cfg} > 5'(MAX_OCTAVES)) begin
      n_clamp = 5'(MAX_OCTAVES);
    end else begin
      n_clamp = {1'b0, oct_cfg};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      phase     <= '0;
      axis      <= '0;
      oct       <= '0;
      n_oct     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != ST_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_acc && cmd.op == OP_EVAL) begin
            crd[0] <= cmd.coord_x[23:0];
            crd[1] <= cmd.coord_y[23:0];
            crd[2] <= cmd.coord_z[23:0];
            n_oct  <= CNT_W'(n_clamp);
            oct    <= '0;
            total  <= '0;
            sum    <= '0;
            amp    <= 17'h10000;
            step   <= '0;
            state  <= ST_OFF;
          end
        end
        // fetch three offsets, form cell index and fraction
        ST_OFF: begin
          if (step != 5'd0) begin
            lat_idx[pos_ax] <= pos[23:16];
            frac[pos_ax]    <= pos[15:0];
          end
          if (step == 5'd3) begin
            step  <= '0;
            axis  <= '0;
            phase <= '0;
            state <= ST_FADE;
          end else begin
            step <= step + 5'd1;
          end
        end
        // quintic fade, three multiplies per axis
        ST_FADE: begin
          unique case (phase)
            2'd0: begin
              t2    <= mul_p[31:0];
              phase <= 2'd1;
            end
            2'd1: begin
              t3      <= mul_p[47:16];
              inner16 <= inner_c[35:16];
              phase   <= 2'd2;
            end
            default: begin
              fade[axis] <= mul_p[47:32];
              phase      <= 2'd0;
              if (axis == 2'd2) begin
                step  <= '0;
                state <= ST_HASH;
              end else begin
                axis <= axis + 2'd1;
              end
            end
          endcase
        end
        // corner hashes through the permutation read port
        ST_HASH: begin
          if (step != 5'd0) begin
            hreg[4'(step - 5'd1)] <= perm_rdata;
          end
          if (step == 5'd14) begin
            step  <= '0;
            phase <= '0;
            state <= ST_LERP;
          end else begin
            step <= step + 5'd1;
          end
        end
        // seven lerps: operands, multiply, add
        ST_LERP: begin
          unique case (phase)
            2'd0: begin
              la    <= la_c;
              ld    <= {lb_c[17], lb_c} - {la_c[17], la_c};
              phase <= 2'd1;
            end
            2'd1: begin
              prod  <= mul_p;
              phase <= 2'd2;
            end
            default: begin
              phase <= 2'd0;
              unique case (step)
                5'd0, 5'd3: x1r <= mix_r;
                5'd1, 5'd4: x2r <= mix_r;
                5'd2:       y1r <= mix_r;
                5'd5:       y2r <= mix_r;
                default:    vr  <= v_c;
              endcase
              if (step == 5'd6) begin
                step  <= '0;
                state <= ST_ACC;
              end else begin
                step <= step + 5'd1;
              end
            end
          endcase
        end
        // weight and accumulate, then next amplitude
        ST_ACC: begin
          if (phase == 2'd0) begin
            prod  <= mul_p;
            phase <= 2'd1;
          end else begin
            total <= total + prod[TOT_W-1:0];
            sum   <= sum + SUM_W'(amp);
            amp   <= mul_p[32:16];
            phase <= 2'd0;
            step  <= '0;
            if (CNT_W'(oct + 1'b1) == n_oct) begin
              state <= ST_DIV;
            end else begin
              oct   <= oct + 1'b1;
              state <= ST_OFF;
            end
          end
        end
        // restoring division, one quotient bit a cycle, saturating at zero and at full scale
        ST_DIV: begin
          if (step == 5'd0) begin
            if (total[TOT_W-1] || total == '0) begin
              quo   <= '0;
              state <= ST_DONE;
            end else if (total[REM_W-1:0] >= dlim) begin
              quo   <= '1;
              state <= ST_DONE;
            end else begin
              rem  <= total[REM_W-1:0];
              dsh  <= REM_W'(dvs) << 15;
              step <= 5'd1;
            end
          end else begin
            if (rem >= dsh) begin
              rem <= rem - dsh;
              quo <= {quo[NOISE_W-2:0], 1'b1};
            end else begin
              quo <= {quo[NOISE_W-2:0], 1'b0};
            end
            dsh <= dsh >> 1;
            if (step == 5'd16) begin
              state <= ST_DONE;
            end else begin
              step <= step + 5'd1;
            end
          end
        end
        // hand the word to the result register
        ST_DONE: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_data  <= quo;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // only an evaluate word leaves idle
  a_idle_stays: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !(cmd.valid && cmd.op == OP_EVAL)) |=> state == ST_IDLE)
    else $error("sequencer left idle without an evaluate word");

  // octave counter stays below the clamped count
  a_oct_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OFF) |-> (oct < n_oct))
    else $error("octave counter out of range");

  // division remainder stays below twice the shifted divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && step != 5'd0) |-> ({1'b0, rem} < {dsh, 1'b0}))
    else $error("division remainder overflow");

  // amplitude never grows from one octave to the next
  a_amp_decay: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && phase == 2'd1) |=> amp <= $past(amp))
    else $error("amplitude grew");

endmodule
